// ----- rtl/core/jacobi_stencil_sweep_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stencil sweep block
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef JACOBI_STENCIL_SWEEP_DEFINES_SVH
`define JACOBI_STENCIL_SWEEP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define JSS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("stencil sweep assertion failed");
// Next-cycle implication, disabled during reset.
`define JSS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("stencil sweep assertion failed");
`else
`define JSS_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define JSS_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

// ----- rtl/core/jss_pkg.sv -----
// ----------------------------------------------------------------------------
// Stencil sweep package
// Shared sizes, defaults and the configuration bundle of the sweep block.
// ----------------------------------------------------------------------------
`default_nettype none

package jss_pkg;

  localparam int VALUE_BITS_DEF = 24;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int DIM_BITS       = 11;
  localparam int IDX_BITS       = 10;
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;

  localparam logic [DIM_BITS-1:0] DIM_MIN = 11'd3;

  typedef struct packed {
    logic [DIM_BITS-1:0] grid_width;
    logic [DIM_BITS-1:0] grid_height;
    logic                written;
  } jss_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/jss_in_if.sv -----
// ----------------------------------------------------------------------------
// Input stream interface
// Carries one old grid value per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface jss_in_if #(
  parameter int VALUE_BITS = jss_pkg::VALUE_BITS_DEF
) ();

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] old_value;

  modport source (output valid, output old_value, input ready);
  modport sink (input valid, input old_value, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/jss_out_if.sv -----
// ----------------------------------------------------------------------------
// Result stream interface
// Carries one updated grid point per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface jss_out_if #(
  parameter int VALUE_BITS = jss_pkg::VALUE_BITS_DEF
) ();
  import jss_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] new_value;
  logic [IDX_BITS-1:0]          out_row;
  logic [IDX_BITS-1:0]          out_col;
  logic [VALUE_BITS-1:0]        max_change;
  logic                         end_of_sweep;

  modport source (
    output valid, output new_value, output out_row, output out_col,
    output max_change, output end_of_sweep, input ready
  );
  modport sink (
    input valid, input new_value, input out_row, input out_col,
    input max_change, input end_of_sweep, output ready
  );

endinterface

`default_nettype wire

// ----- rtl/core/jss_line_cell.sv -----
// ----------------------------------------------------------------------------
// Line store cell
// One row of delay: a single-port-write, single-port-read memory with a
// registered read, chained so that each cell passes its row to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module jss_line_cell #(
  parameter int DEPTH      = jss_pkg::MAX_WIDTH_DEF,
  parameter int VALUE_BITS = jss_pkg::VALUE_BITS_DEF,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [ADDR_BITS-1:0]  rd_addr,
  output logic [VALUE_BITS-1:0] rd_data,
  input  logic                  wr_en,
  input  logic [ADDR_BITS-1:0]  wr_addr,
  input  logic [VALUE_BITS-1:0] wr_data
);

  logic [VALUE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jss_apb_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the grid width and height.
// ----------------------------------------------------------------------------
`default_nettype none

module jss_apb_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [jss_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [jss_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [jss_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output jss_pkg::jss_cfg_t                  cfg
);
  import jss_pkg::*;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;
  localparam logic [DIM_BITS-1:0] DIM_RESET = 11'd64;

  logic [DIM_BITS-1:0] grid_width;
  logic [DIM_BITS-1:0] grid_height;
  logic                wr_fire;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;
  // Registers sit on 4-byte steps, so one address bit picks the register.
  assign reg_sel = paddr[APB_ADDR_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_RESET;
      grid_height <= DIM_RESET;
    end else if (wr_fire) begin
      unique case (reg_sel)
        REG_GRID_WIDTH:  grid_width  <= pwdata[DIM_BITS-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GRID_WIDTH:  prdata = {{(APB_DATA_BITS-DIM_BITS){1'b0}}, grid_width};
      REG_GRID_HEIGHT: prdata = {{(APB_DATA_BITS-DIM_BITS){1'b0}}, grid_height};
      default:         prdata = '0;
    endcase
  end

  assign cfg.grid_width  = grid_width;
  assign cfg.grid_height = grid_height;
  assign cfg.written     = wr_fire;

endmodule

`default_nettype wire

// ----- rtl/core/jacobi_stencil_sweep.sv -----
// ----------------------------------------------------------------------------
// Five-point Jacobi stencil sweep
// A result is offered from the stage 3 slots after its item has passed stages 1 and 2.
// Throughput: one item per cycle unless the result side stalls; each item on
// the last grid row gives two results over the single result channel.
// Reset clears counters, running maximum and stage flags, sets a 64 x 64 grid
// and leaves the two line stores as they are.
// ----------------------------------------------------------------------------
`default_nettype none
`include "jacobi_stencil_sweep_defines.svh"

module jacobi_stencil_sweep #(
  parameter int MAX_WIDTH    = jss_pkg::MAX_WIDTH_DEF,
  localparam int VALUE_BITS  = jss_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  jss_in_if.sink                            samples,
  jss_out_if.source                         results,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [jss_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [jss_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [jss_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import jss_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = IDX_BITS;
  localparam int EXT_BITS = ($clog2(MAX_WIDTH + 1) > DIM_BITS) ?
                            $clog2(MAX_WIDTH + 1) : DIM_BITS;
  localparam int SUM_BITS = VALUE_BITS + 2;
  localparam logic [EXT_BITS-1:0]   WIDTH_CAP  = EXT_BITS'(MAX_WIDTH);
  localparam logic [DIM_BITS-1:0]   HEIGHT_CAP = DIM_BITS'(MAX_HEIGHT);
  localparam logic [VALUE_BITS-1:0] SIGN_MASK  = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct packed {
    logic has_first;
    logic interior;
    logic last_row;
    logic last_col;
  } pos_flags_t;

  // Configuration and effective grid size
  jss_cfg_t cfg;

  jss_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [EXT_BITS-1:0] width_ext;
  logic [EXT_BITS-1:0] eff_w;
  logic [EXT_BITS-1:0] w_last;
  logic [DIM_BITS-1:0] eff_h;
  logic [DIM_BITS-1:0] h_last;

  assign width_ext = EXT_BITS'(cfg.grid_width);

  always_comb begin
    if (cfg.grid_width < DIM_MIN) begin
      eff_w = EXT_BITS'(DIM_MIN);
    end else if (width_ext > WIDTH_CAP) begin
      eff_w = WIDTH_CAP;
    end else begin
      eff_w = width_ext;
    end
    if (cfg.grid_height < DIM_MIN) begin
      eff_h = DIM_MIN;
    end else if (cfg.grid_height > HEIGHT_CAP) begin
      eff_h = HEIGHT_CAP;
    end else begin
      eff_h = cfg.grid_height;
    end
  end

  assign w_last = eff_w - EXT_BITS'(1);
  assign h_last = eff_h - DIM_BITS'(1);

  // Raster position of the next input item
  logic [COL_BITS-1:0] col_cnt;
  logic [ROW_BITS-1:0] row_cnt;
  logic [EXT_BITS-1:0] col_ext;
  logic [DIM_BITS-1:0] row_ext;
  logic                at_last_col;
  logic                at_last_row;
  logic                accept;
  pos_flags_t          pos;

  assign col_ext     = EXT_BITS'(col_cnt);
  assign row_ext     = DIM_BITS'(row_cnt);
  assign at_last_col = (col_ext == w_last);
  assign at_last_row = (row_ext == h_last);
  assign accept      = samples.valid && samples.ready;

  assign pos.has_first = (row_cnt != '0);
  assign pos.interior  = (row_cnt >= ROW_BITS'(2)) && (col_cnt != '0) && !at_last_col;
  assign pos.last_row  = at_last_row;
  assign pos.last_col  = at_last_col;

  always_ff @(posedge clk) begin
    if (rst || cfg.written) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_cnt <= '0;
        row_cnt <= at_last_row ? '0 : row_cnt + ROW_BITS'(1);
      end else begin
        col_cnt <= col_cnt + COL_BITS'(1);
      end
    end
  end

  // Stage 1: line store reads land here. The upper store is read one column
  // ahead; at the row end it wraps to column 0, which already holds this row
  // and so serves as the center of the next row's first point.
  logic                  s1_valid;
  logic [VALUE_BITS-1:0] s1_x;
  logic [COL_BITS-1:0]   s1_col;
  logic [ROW_BITS-1:0]   s1_row;
  pos_flags_t            s1_pos;
  logic                  s1_move;
  logic                  s1_free;

  logic [COL_BITS-1:0]   up_rd_addr;
  logic [VALUE_BITS-1:0] east;
  logic [VALUE_BITS-1:0] north;
  logic [VALUE_BITS-1:0] center;
  logic [VALUE_BITS-1:0] west;
  logic [SUM_BITS-1:0]   sum;
  logic [VALUE_BITS-1:0] s1_nv;

  assign up_rd_addr = at_last_col ? '0 : col_cnt + COL_BITS'(1);

  jss_line_cell #(
    .DEPTH      (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_upper (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (up_rd_addr),
    .rd_data (east),
    .wr_en   (s1_move),
    .wr_addr (s1_col),
    .wr_data (s1_x)
  );

  jss_line_cell #(
    .DEPTH      (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_lower (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cnt),
    .rd_data (north),
    .wr_en   (s1_move),
    .wr_addr (s1_col),
    .wr_data (center)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Values are kept in offset binary so that the floor of the average and
  // the absolute difference are plain unsigned operations.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x   <= VALUE_BITS'(samples.old_value) ^ SIGN_MASK;
      s1_col <= col_cnt;
      s1_row <= row_cnt;
      s1_pos <= pos;
    end
    if (s1_move) begin
      west   <= center;
      center <= east;
    end
  end

  assign sum = SUM_BITS'(north) + SUM_BITS'(s1_x) + SUM_BITS'(west) + SUM_BITS'(east);
  assign s1_nv = s1_pos.interior ? sum[SUM_BITS-1:2] : center;

  // Stage 2: change against the old center and running maximum
  logic                  s2_valid;
  logic [VALUE_BITS-1:0] s2_nv;
  logic [VALUE_BITS-1:0] s2_center;
  logic [VALUE_BITS-1:0] s2_x;
  logic [COL_BITS-1:0]   s2_col;
  logic [ROW_BITS-1:0]   s2_row;
  pos_flags_t            s2_pos;
  logic                  s2_move;
  logic                  s2_free;
  logic                  s2_eos;
  logic [VALUE_BITS-1:0] diff;
  logic [VALUE_BITS-1:0] run_max;
  logic [VALUE_BITS-1:0] max_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_nv     <= s1_nv;
      s2_center <= center;
      s2_x      <= s1_x;
      s2_col    <= s1_col;
      s2_row    <= s1_row;
      s2_pos    <= s1_pos;
    end
  end

  assign diff     = (s2_nv >= s2_center) ? s2_nv - s2_center : s2_center - s2_nv;
  assign max_next = (s2_pos.interior && (diff > run_max)) ? diff : run_max;
  assign s2_eos   = s2_pos.last_row && s2_pos.last_col;

  always_ff @(posedge clk) begin
    if (rst || cfg.written) begin
      run_max <= '0;
    end else if (s2_move) begin
      run_max <= s2_eos ? '0 : max_next;
    end
  end

  // Stage 3: up to two result slots per item, offered in order.
  logic                  p0;
  logic                  p1;
  logic [VALUE_BITS-1:0] s3_nv;
  logic [VALUE_BITS-1:0] s3_x;
  logic [COL_BITS-1:0]   s3_col;
  logic [ROW_BITS-1:0]   s3_row;
  logic [VALUE_BITS-1:0] s3_max;
  logic                  s3_eos;
  logic                  out_fire;
  logic                  s3_take;

  assign out_fire = results.valid && results.ready;
  assign s3_take  = !(p0 || p1) || (out_fire && !(p0 && p1));
  assign s2_free  = !s2_valid || s3_take;
  assign s2_move  = s2_valid && s3_take;
  assign s1_free  = !s1_valid || s2_free;
  assign s1_move  = s1_valid && s2_free;
  assign samples.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0 <= 1'b0;
      p1 <= 1'b0;
    end else if (s2_move) begin
      p0 <= s2_pos.has_first;
      p1 <= s2_pos.last_row;
    end else if (out_fire) begin
      if (p0) begin
        p0 <= 1'b0;
      end else begin
        p1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_nv  <= s2_nv;
      s3_x   <= s2_x;
      s3_col <= s2_col;
      s3_row <= s2_row;
      s3_eos <= s2_eos;
      s3_max <= s2_eos ? max_next : '0;
    end
  end

  // The first slot is the point one row up; the second is the pass-through
  // point of the last row.
  assign results.valid        = p0 || p1;
  assign results.new_value    = $signed(p0 ? (s3_nv ^ SIGN_MASK) : (s3_x ^ SIGN_MASK));
  assign results.out_row      = p0 ? IDX_BITS'(s3_row - ROW_BITS'(1)) : IDX_BITS'(s3_row);
  assign results.out_col      = IDX_BITS'(s3_col);
  assign results.max_change   = p0 ? '0 : s3_max;
  assign results.end_of_sweep = !p0 && s3_eos;

  `JSS_ASSERT_IMP(a_max_only_at_end, clk, rst,
    results.valid && !results.end_of_sweep, results.max_change == '0)
  `JSS_ASSERT_NXT(a_max_clears_at_end, clk, rst,
    s2_move && s2_eos, run_max == '0)
  `JSS_ASSERT_IMP(a_stall_means_full, clk, rst,
    !samples.ready, s1_valid && s2_valid)
  `JSS_ASSERT_IMP(a_position_in_grid, clk, rst,
    1'b1, (col_ext < eff_w) && (row_ext < eff_h))

endmodule

`default_nettype wire

// ----- test/jss_sweep_checker.sv -----
// ----------------------------------------------------------------------------
// Stencil sweep checker
// Watches the sample and result channels and the register port, keeps its own
// copy of the line stores, raster position and running maximum, predicts every
// updated grid point and compares the results in order.
// ----------------------------------------------------------------------------
package jss_tb_pkg;

  typedef enum int {
    REG_GRID_WIDTH  = 0,
    REG_GRID_HEIGHT = 1
  } sweep_reg_e;

endpackage

module jss_sweep_checker
  import jss_pkg::*;
  import jss_tb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  jss_in_if                        samples,
  jss_out_if                       results,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  input  logic [APB_DATA_BITS-1:0] prdata,
  input  logic                     pready,
  output int                       mismatches,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB           = VALUE_BITS_DEF;
  localparam int REPORT_LIMIT = 10;
  // Values are kept in offset binary so that the floor divide and the
  // absolute difference work on plain unsigned numbers.
  localparam logic [VB-1:0] SIGN_FLIP = {1'b1, {(VB-1){1'b0}}};

  typedef struct packed {
    logic [VB-1:0]       value;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic [VB-1:0]       peak;
    logic                last;
  } grid_point_t;

  logic [VB-1:0]       even_rows [MAX_WIDTH_DEF];
  logic [VB-1:0]       odd_rows  [MAX_WIDTH_DEF];
  logic [DIM_BITS-1:0] width_reg;
  logic [DIM_BITS-1:0] height_reg;
  int unsigned         row_pos;
  int unsigned         col_pos;
  logic [VB-1:0]       peak_change;
  grid_point_t         expected_points [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic int unsigned clamp_dim(logic [DIM_BITS-1:0] v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic queue_point(input logic [VB-1:0] biased, input int unsigned r,
                             input int unsigned c, input logic last);
    grid_point_t p;
    p.value = biased ^ SIGN_FLIP;
    p.row   = IDX_BITS'(r);
    p.col   = IDX_BITS'(c);
    p.peak  = last ? peak_change : '0;
    p.last  = last;
    expected_points.push_back(p);
  endtask

  task automatic predict_item(input logic [VB-1:0] raw);
    int unsigned   w;
    int unsigned   h;
    int unsigned   r;
    int unsigned   c;
    logic          odd_row;
    logic [VB-1:0] x;
    logic [VB-1:0] center;
    logic [VB-1:0] north;
    logic [VB-1:0] west;
    logic [VB-1:0] east;
    logic [VB-1:0] nv;
    logic [VB-1:0] delta;
    logic [VB+1:0] total;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    r = row_pos;
    c = col_pos;
    x = raw ^ SIGN_FLIP;
    if (c >= w || r >= h) begin
      r = 0;
      c = 0;
    end
    odd_row = r[0];
    // The store of the other parity holds the row above; the one of the same
    // parity still holds the row two above until this item overwrites it.
    if (r >= 1) begin
      center = odd_row ? even_rows[c] : odd_rows[c];
      nv     = center;
      if (r != 1 && c != 0 && c != w - 1) begin
        north = odd_row ? odd_rows[c] : even_rows[c];
        west  = odd_row ? even_rows[c-1] : odd_rows[c-1];
        east  = odd_row ? even_rows[c+1] : odd_rows[c+1];
        total = north + x + west + east;
        nv    = total[VB+1:2];
        delta = (nv > center) ? nv - center : center - nv;
        if (delta > peak_change) peak_change = delta;
      end
      queue_point(nv, r - 1, c, 1'b0);
    end
    if (odd_row) odd_rows[c] = x;
    else even_rows[c] = x;
    if (r == h - 1) queue_point(x, r, c, c == w - 1);
    if (c + 1 >= w) begin
      c = 0;
      if (r + 1 >= h) begin
        r = 0;
        peak_change = '0;
      end else begin
        r = r + 1;
      end
    end else begin
      c = c + 1;
    end
    row_pos = r;
    col_pos = c;
  endtask

  task automatic check_point();
    grid_point_t got;
    grid_point_t want;
    got = {results.new_value, results.out_row, results.out_col,
           results.max_change, results.end_of_sweep};
    if (expected_points.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected point at row %0d col %0d", got.row, got.col);
    end else begin
      want = expected_points.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("point mismatch: expected (%0d,%0d) value %0d max_change %0d end %0b",
                   want.row, want.col, $signed(want.value), want.peak, want.last);
          $display("                got      (%0d,%0d) value %0d max_change %0d end %0b",
                   got.row, got.col, $signed(got.value), got.peak, got.last);
        end
      end
    end
  endtask

  task automatic register_access();
    int                       reg_index;
    logic [APB_DATA_BITS-1:0] want;
    reg_index = int'(paddr) / 4;
    if (pwrite) begin
      case (reg_index)
        REG_GRID_WIDTH: width_reg = pwdata[DIM_BITS-1:0];
        REG_GRID_HEIGHT: height_reg = pwdata[DIM_BITS-1:0];
        default: return;
      endcase
      // Any register write restarts the sweep; the stores keep their rows.
      row_pos     = 0;
      col_pos     = 0;
      peak_change = '0;
    end else begin
      case (reg_index)
        REG_GRID_WIDTH: want = APB_DATA_BITS'(width_reg);
        REG_GRID_HEIGHT: want = APB_DATA_BITS'(height_reg);
        default: return;
      endcase
      if (prdata !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("register read mismatch at %0d: expected %0d got %0d",
                   paddr, want, prdata);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg   = DIM_BITS'(64);
      height_reg  = DIM_BITS'(64);
      row_pos     = 0;
      col_pos     = 0;
      peak_change = '0;
      expected_points.delete();
    end else begin
      // A result leaves only after its item has passed the registered stages of the block,
      // so the result seen at this edge never belongs to the item accepted at it.
      if (results.valid && results.ready) check_point();
      if (samples.valid && samples.ready) predict_item(samples.old_value);
      if (psel && penable && pready) register_access();
    end
    pending = expected_points.size();
  end

endmodule

// ----- test/jacobi_stencil_sweep_tb.sv -----
// ----------------------------------------------------------------------------
// Stencil sweep testbench
// Drives raster-ordered grid values through the sweep block over a range of
// grid sizes, including clamped and largest sizes and sweeps cut short by a
// register write, with random idling on both channels and one long result
// stall. The checker beside the block predicts and compares every point.
// ----------------------------------------------------------------------------
module jacobi_stencil_sweep_tb;
  import jss_pkg::*;
  import jss_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 12;
  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 400;
  localparam int WIDE_TAIL    = 64;
  localparam int TALL_ROWS    = 20;
  localparam int VB           = VALUE_BITS_DEF;
  localparam logic signed [VB-1:0] TEMP_MIN = {1'b1, {(VB-1){1'b0}}};
  localparam logic signed [VB-1:0] TEMP_MAX = {1'b0, {(VB-1){1'b1}}};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  int                       mismatches;
  int                       pending;
  int                       quiet_cycles = 0;
  int                       send_idle_pct = 20;
  int                       recv_idle_pct = 20;
  bit                       hold_off_req = 1'b0;
  int                       grid_w = 64;
  int                       grid_h = 64;
  int                       random_sent = 0;

  jss_in_if  samples_ch ();
  jss_out_if results_ch ();

  jacobi_stencil_sweep i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  jss_sweep_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples_ch),
    .results    (results_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(int pct);
    int roll;
    if (int'($urandom_range(99)) >= pct) return 0;
    roll = $urandom_range(99);
    if (roll < 85) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic signed [VB-1:0] random_temp();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return TEMP_MIN;
          1: return TEMP_MAX;
          2: return '0;
          3: return '1;
          default: return VB'(1);
        endcase
      end
      1, 2: return VB'(int'($urandom_range(2000)) - 1000);
      default: return VB'($urandom);
    endcase
  endfunction

  function automatic int grid_dim(logic [APB_DATA_BITS-1:0] word, int hi);
    int v;
    v = word[DIM_BITS-1:0];
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Result side: random stalls, plus one long hold on request.
  initial begin
    int stall;
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = pick_gap(recv_idle_pct);
      end
      if (stall > 0) begin
        results_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      results_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) ||
        (results_ch.valid && results_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid stays high from one item to the next; it is lowered only for a gap
  // or when the channel goes quiet.
  task automatic push_temp(input logic signed [VB-1:0] v);
    int gap;
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_ch.valid     <= 1'b1;
    samples_ch.old_value <= v;
    do @(posedge clk); while (!samples_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    samples_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_transfer(input bit is_write, input sweep_reg_e idx,
                              input logic [APB_DATA_BITS-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= APB_ADDR_BITS'(4 * idx);
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write a register and read it back; the checker compares the read data.
  task automatic set_register(input sweep_reg_e idx, input logic [APB_DATA_BITS-1:0] word);
    apb_transfer(1'b1, idx, word);
    apb_transfer(1'b0, idx, '0);
    if (idx == REG_GRID_WIDTH) grid_w = grid_dim(word, MAX_WIDTH_DEF);
    else grid_h = grid_dim(word, MAX_HEIGHT);
  endtask

  task automatic configure(input logic [APB_DATA_BITS-1:0] width_word,
                           input logic [APB_DATA_BITS-1:0] height_word);
    wait_drained();
    set_register(REG_GRID_WIDTH, width_word);
    set_register(REG_GRID_HEIGHT, height_word);
  endtask

  initial begin
    int                       mode;
    int                       cells;
    int                       count;
    logic [APB_DATA_BITS-1:0] width_word;
    logic [APB_DATA_BITS-1:0] height_word;
    samples_ch.valid     = 1'b0;
    samples_ch.old_value = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Width written below the minimum, height at it with upper bits set.
    // The lone interior point sees full-scale neighbours around a minimum
    // center, so the change is the largest possible.
    configure(32'h0000_0000, 32'hFFFF_F803);
    push_temp('0);       push_temp(TEMP_MAX); push_temp('1);
    push_temp(TEMP_MAX); push_temp(TEMP_MIN); push_temp(TEMP_MAX);
    push_temp(VB'(1));   push_temp(TEMP_MAX); push_temp('0);
    // Second sweep right after the wrap: a negative sum of -5 must floor to -2.
    push_temp(TEMP_MAX); push_temp('1);       push_temp(TEMP_MIN);
    push_temp('1);       push_temp(TEMP_MAX); push_temp(VB'(-2));
    push_temp('0);       push_temp('1);       push_temp(VB'(1));
    // A sweep cut short in its second row by the next register write.
    configure(32'd5, 32'd4);
    repeat (7) push_temp(random_temp());

    // Full-rate sender against a long result stall fills the block.
    send_idle_pct = 0;
    configure(32'd8, 32'd8);
    hold_off_req = 1'b1;
    repeat (64) push_temp(random_temp());
    random_sent = 64;

    while (random_sent < RANDOM_ITEMS) begin
      mode          = $urandom_range(9);
      send_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
      recv_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
      width_word    = ($urandom & 32'hFFFF_F800) | $urandom_range(12, 3);
      height_word   = $urandom_range(8, 3);
      if (mode == 0) width_word = ($urandom & 32'hFFFF_F800) | $urandom_range(2);
      if (mode == 1) height_word = ($urandom & 32'hFFFF_F800) | $urandom_range(2);
      wait_drained();
      if (mode == 2) begin
        set_register(REG_GRID_HEIGHT, height_word);
      end else if (mode == 3) begin
        set_register(REG_GRID_HEIGHT, height_word);
        set_register(REG_GRID_WIDTH, width_word);
      end else begin
        set_register(REG_GRID_WIDTH, width_word);
        set_register(REG_GRID_HEIGHT, height_word);
      end
      cells = grid_w * grid_h;
      count = $urandom_range(3, 1) * cells;
      // Some phases stop mid-grid, so the next write lands inside a sweep.
      if ($urandom_range(4) == 0)
        count = $urandom_range(cells - 1, 1) + (($urandom_range(1) == 1) ? cells : 0);
      repeat (count) push_temp(random_temp());
      random_sent += count;
    end

    // Largest width, cut short early in the second row, then a height above
    // the largest over its first rows.
    send_idle_pct = 10;
    recv_idle_pct = 10;
    configure(32'd1024, 32'd2);
    repeat (grid_w + WIDE_TAIL) push_temp(random_temp());
    configure(32'd3, 32'd2047);
    repeat (grid_w * TALL_ROWS) push_temp(random_temp());

    wait_drained();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/jss_pkg.sv
rtl/core/jss_in_if.sv
rtl/core/jss_out_if.sv
rtl/core/jss_line_cell.sv
rtl/core/jss_apb_regs.sv
rtl/core/jacobi_stencil_sweep.sv
test/jss_sweep_checker.sv
test/jacobi_stencil_sweep_tb.sv
